// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the hash table RTL, clocked on clk_i and gated by rst_ni
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define LPHT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define LPHT_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");
`else
`define LPHT_ASSERT(lbl, prop)
`define LPHT_ASSERT_NEVER(lbl, expr)
`endif

`endif

// ===== rtl/core/lpht_pkg.sv =====
// Types, codes and constants shared by the hash table modules
`default_nettype none
package lpht_pkg;

  localparam int SLOTS_DEF    = 1024;
  localparam int SIZE_RST     = 1024;
  localparam int KEY_W        = 64;
  localparam int VAL_W        = 64;
  localparam int OP_W         = 2;
  localparam int STATUS_W     = 3;
  localparam int CFG_W        = 11;
  localparam int DIV_BITS     = 4;
  localparam int DIV_STEPS    = KEY_W / DIV_BITS;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
  localparam int          SHR_0  = 30;
  localparam int          SHR_1  = 27;
  localparam int          SHR_2  = 31;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2
  } req_op_e;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_USED  = 2'd1,
    ST_TOMB  = 2'd2
  } slot_st_e;

  typedef enum logic [2:0] {
    RS_OK       = 3'd0,
    RS_NOTFOUND = 3'd1,
    RS_DUP      = 3'd2,
    RS_FULL     = 3'd3,
    RS_NULL     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    EV_CONT,
    EV_HIT,
    EV_MISS,
    EV_DUP,
    EV_INS,
    EV_FULL
  } probe_ev_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_HASH,
    S_READ,
    S_EVAL,
    S_DONE
  } ctrl_st_e;

  typedef enum logic [2:0] {
    H_IDLE,
    H_M0,
    H_M1,
    H_M2,
    H_DIV,
    H_DONE
  } hash_ph_e;

  typedef struct packed {
    logic clear_step;
    logic load_req;
    logic early;
    logic hash_start;
    logic init_probe;
    logic rd;
    logic advance;
    logic finish;
    logic out_load;
  } lpht_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic early_done;
    logic hash_done;
    logic ev_cont;
    logic out_busy;
  } lpht_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/lpht_ifs.sv =====
// Valid/ready channel interfaces for requests, responses and the size register
`default_nettype none
interface lpht_req_if;
  logic                         valid;
  logic                         ready;
  logic [lpht_pkg::OP_W-1:0]    req_type;
  logic [lpht_pkg::KEY_W-1:0]   key;
  logic [lpht_pkg::VAL_W-1:0]   value;
  modport source (output valid, req_type, key, value, input ready);
  modport sink   (input valid, req_type, key, value, output ready);
endinterface

interface lpht_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [lpht_pkg::STATUS_W-1:0]   status;
  logic [lpht_pkg::VAL_W-1:0]      result_value;
  modport source (output valid, status, result_value, input ready);
  modport sink   (input valid, status, result_value, output ready);
endinterface

interface lpht_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [lpht_pkg::CFG_W-1:0]   table_size;
  modport source (output valid, table_size, input ready);
  modport sink   (input valid, table_size, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lpht_hash.sv =====
// Multi-cycle home slot unit: 64-bit mix on a shared 32x32 multiplier, then radix-16 remainder
`default_nettype none
module lpht_hash #(
  parameter int SLOTS = lpht_pkg::SLOTS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [lpht_pkg::KEY_W-1:0]    key_i,
  input  wire logic [$clog2(SLOTS+1)-1:0]    size_i,
  output logic                               done_o,
  output logic [$clog2(SLOTS)-1:0]           home_o
);
  import lpht_pkg::*;

  localparam int IW  = $clog2(SLOTS);
  localparam int SZW = $clog2(SLOTS+1);

  hash_ph_e             ph_q, ph_d;
  logic                 rnd_q;
  logic [63:0]          a_q, acc_q;
  logic [SZW-1:0]       rem_q;
  logic [DIV_CNT_W-1:0] cnt_q;

  logic [63:0] cmul;
  logic [31:0] op_a, op_b;
  logic [63:0] prod;
  logic [63:0] acc_sum;
  logic [SZW-1:0] rem_nx;
  logic [63:0]    a_nx;

  assign cmul    = rnd_q ? MIX_C2 : MIX_C1;
  assign op_a    = (ph_q == H_M1) ? a_q[63:32] : a_q[31:0];
  assign op_b    = (ph_q == H_M2) ? cmul[63:32] : cmul[31:0];
  assign prod    = {32'b0, op_a} * {32'b0, op_b};
  assign acc_sum = {acc_q[63:32] + prod[31:0], acc_q[31:0]};

  // four restoring remainder steps per cycle, bits of the mixed key taken from the top
  always_comb begin
    logic [SZW:0]   t;
    logic [SZW-1:0] r;
    logic [63:0]    a;
    r = rem_q;
    a = a_q;
    for (int k = 0; k < DIV_BITS; k++) begin
      t = {r, a[63]};
      a = {a[62:0], 1'b0};
      if (t >= {1'b0, size_i}) begin
        t = t - {1'b0, size_i};
      end
      r = t[SZW-1:0];
    end
    rem_nx = r;
    a_nx   = a;
  end

  always_comb begin
    ph_d = ph_q;
    unique case (ph_q)
      H_IDLE: if (start_i) ph_d = H_M0;
      H_M0:   ph_d = H_M1;
      H_M1:   ph_d = H_M2;
      H_M2:   ph_d = rnd_q ? H_DIV : H_M0;
      H_DIV:  if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) ph_d = H_DONE;
      H_DONE: ph_d = H_IDLE;
      default: ph_d = H_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= H_IDLE;
      rnd_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      ph_q <= ph_d;
      if (ph_q == H_IDLE) rnd_q <= 1'b0;
      else if (ph_q == H_M2) rnd_q <= 1'b1;
      if (ph_q == H_DIV) cnt_q <= cnt_q + 1'b1;
      else cnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (ph_q)
      H_IDLE: begin
        a_q   <= key_i ^ (key_i >> SHR_0);
        rem_q <= '0;
      end
      H_M0: acc_q <= prod;
      H_M1: acc_q <= acc_sum;
      H_M2: begin
        if (rnd_q) a_q <= acc_sum ^ (acc_sum >> SHR_2);
        else a_q <= acc_sum ^ (acc_sum >> SHR_1);
      end
      H_DIV: begin
        a_q   <= a_nx;
        rem_q <= rem_nx;
      end
      default: ;
    endcase
  end

  assign done_o = (ph_q == H_DONE);
  assign home_o = rem_q[IW-1:0];

endmodule
`default_nettype wire

// ===== rtl/core/lpht_ctrl.sv =====
// Request sequencer: clear sweep, checks, hashing, probe loop and result hand-off
`default_nettype none
module lpht_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic                 req_valid_i,
  output logic                      req_ready_o,
  input  wire lpht_pkg::lpht_stat_t stat_i,
  output lpht_pkg::lpht_cmd_t       cmd_o
);
  import lpht_pkg::*;

  ctrl_st_e st_q, st_d;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_CLEAR: if (stat_i.clear_last) st_d = S_IDLE;
      S_IDLE:  if (req_valid_i) st_d = S_CHECK;
      S_CHECK: st_d = stat_i.early_done ? S_DONE : S_HASH;
      S_HASH:  if (stat_i.hash_done) st_d = S_READ;
      S_READ:  st_d = S_EVAL;
      S_EVAL:  st_d = stat_i.ev_cont ? S_READ : S_DONE;
      S_DONE:  if (!stat_i.out_busy) st_d = S_IDLE;
      default: st_d = S_CLEAR;
    endcase
    // a size write restarts the clear sweep
    if (cfg_we_i) st_d = S_CLEAR;
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.clear_step = (st_q == S_CLEAR);
    cmd_o.load_req   = (st_q == S_IDLE) && req_valid_i;
    cmd_o.early      = (st_q == S_CHECK) && stat_i.early_done;
    cmd_o.hash_start = (st_q == S_CHECK) && !stat_i.early_done;
    cmd_o.init_probe = (st_q == S_HASH) && stat_i.hash_done;
    cmd_o.rd         = (st_q == S_READ);
    cmd_o.advance    = (st_q == S_EVAL) && stat_i.ev_cont;
    cmd_o.finish     = (st_q == S_EVAL) && !stat_i.ev_cont;
    cmd_o.out_load   = (st_q == S_DONE) && !stat_i.out_busy;
  end

  assign req_ready_o = (st_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLEAR;
    end else begin
      st_q <= st_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lpht_dp.sv =====
// Datapath: slot memories, size and count registers, probe pointer, result and output registers
`default_nettype none
module lpht_dp #(
  parameter int SLOTS = lpht_pkg::SLOTS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [lpht_pkg::CFG_W-1:0]      cfg_size_i,
  input  wire logic [lpht_pkg::OP_W-1:0]       req_type_i,
  input  wire logic [lpht_pkg::KEY_W-1:0]      key_i,
  input  wire logic [lpht_pkg::VAL_W-1:0]      value_i,
  input  wire logic                            rsp_ready_i,
  output logic                                 rsp_valid_o,
  output logic [lpht_pkg::STATUS_W-1:0]        status_o,
  output logic [lpht_pkg::VAL_W-1:0]           result_value_o,
  input  wire lpht_pkg::lpht_cmd_t             cmd_i,
  output lpht_pkg::lpht_stat_t                 stat_o
);
  import lpht_pkg::*;
  `include "assert_macros.svh"

  localparam int IW       = $clog2(SLOTS);
  localparam int SZW      = $clog2(SLOTS+1);
  localparam int RST_SIZE = (SIZE_RST < SLOTS) ? SIZE_RST : SLOTS;

  logic [SZW-1:0]   size_q, count_q, size_in;
  logic [IW-1:0]    clr_q, pos_q, idx_q, dest_q, wdest;
  logic             tomb_q;
  logic [OP_W-1:0]  op_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;

  logic [1:0]             st_mem [SLOTS];
  logic [KEY_W+VAL_W-1:0] kv_mem [SLOTS];
  logic [1:0]             st_rd_q;
  logic [KEY_W+VAL_W-1:0] kv_rd_q;

  logic [STATUS_W-1:0] res_st_q;
  logic [VAL_W-1:0]    res_val_q;
  logic                out_valid_q;

  logic                hash_done;
  logic [IW-1:0]       home;
  logic                early_done, last, match;
  logic [STATUS_W-1:0] early_st;
  probe_ev_e           ev;
  logic                st_we;
  logic [IW-1:0]       st_wa;
  logic [1:0]          st_wd;

  lpht_hash #(.SLOTS(SLOTS)) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.hash_start),
    .key_i   (key_q),
    .size_i  (size_q),
    .done_o  (hash_done),
    .home_o  (home)
  );

  // zero reads as one, anything past the slot count as the slot count
  always_comb begin
    if (cfg_size_i == '0) size_in = SZW'(1);
    else if (int'(cfg_size_i) > SLOTS) size_in = SZW'(SLOTS);
    else size_in = SZW'(cfg_size_i);
  end

  always_comb begin
    early_done = 1'b1;
    early_st   = RS_NOTFOUND;
    case (op_q)
      OP_INSERT: begin
        if (val_q == '0) early_st = RS_NULL;
        else if (count_q >= size_q) early_st = RS_FULL;
        else early_done = 1'b0;
      end
      OP_LOOKUP, OP_REMOVE: early_done = (count_q == '0);
      default: ;
    endcase
  end

  assign last  = (SZW'(idx_q) + SZW'(1)) == size_q;
  assign match = (st_rd_q == ST_USED) && (kv_rd_q[KEY_W+VAL_W-1:VAL_W] == key_q);
  assign wdest = tomb_q ? dest_q : pos_q;

  always_comb begin
    ev = EV_CONT;
    if (op_q == OP_INSERT) begin
      if (match) ev = EV_DUP;
      else if (st_rd_q == ST_EMPTY) ev = EV_INS;
      else if (last) ev = (tomb_q || st_rd_q == ST_TOMB) ? EV_INS : EV_FULL;
    end else begin
      if (st_rd_q == ST_EMPTY) ev = EV_MISS;
      else if (match) ev = EV_HIT;
      else if (last) ev = EV_MISS;
    end
  end

  always_comb begin
    st_we = 1'b0;
    st_wa = clr_q;
    st_wd = ST_EMPTY;
    if (cmd_i.clear_step) begin
      st_we = 1'b1;
    end else if (cmd_i.finish && ev == EV_HIT && op_q == OP_REMOVE) begin
      st_we = 1'b1;
      st_wa = pos_q;
      st_wd = ST_TOMB;
    end else if (cmd_i.finish && ev == EV_INS) begin
      st_we = 1'b1;
      st_wa = wdest;
      st_wd = ST_USED;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) st_mem[st_wa] <= st_wd;
    if (cmd_i.finish && ev == EV_INS) kv_mem[wdest] <= {key_q, val_q};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      st_rd_q <= st_mem[pos_q];
      kv_rd_q <= kv_mem[pos_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= SZW'(RST_SIZE);
      count_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        size_q  <= size_in;
        count_q <= '0;
        clr_q   <= '0;
      end else begin
        if (cmd_i.clear_step) clr_q <= clr_q + 1'b1;
        if (cmd_i.finish && ev == EV_INS) count_q <= count_q + 1'b1;
        else if (cmd_i.finish && ev == EV_HIT && op_q == OP_REMOVE)
          count_q <= count_q - 1'b1;
      end
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (rsp_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      op_q  <= req_type_i;
      key_q <= key_i;
      val_q <= value_i;
    end
    if (cmd_i.init_probe) begin
      pos_q  <= home;
      idx_q  <= '0;
      tomb_q <= 1'b0;
    end
    if (cmd_i.advance) begin
      pos_q <= ((SZW'(pos_q) + SZW'(1)) == size_q) ? '0 : pos_q + 1'b1;
      idx_q <= idx_q + 1'b1;
      // remember the first tombstone on the path
      if (op_q == OP_INSERT && st_rd_q == ST_TOMB && !tomb_q) begin
        tomb_q <= 1'b1;
        dest_q <= pos_q;
      end
    end
    if (cmd_i.early) begin
      res_st_q  <= early_st;
      res_val_q <= '0;
    end
    if (cmd_i.finish) begin
      case (ev)
        EV_HIT: begin
          res_st_q  <= RS_OK;
          res_val_q <= kv_rd_q[VAL_W-1:0];
        end
        EV_INS: begin
          res_st_q  <= RS_OK;
          res_val_q <= '0;
        end
        EV_DUP: begin
          res_st_q  <= RS_DUP;
          res_val_q <= '0;
        end
        EV_FULL: begin
          res_st_q  <= RS_FULL;
          res_val_q <= '0;
        end
        default: begin
          res_st_q  <= RS_NOTFOUND;
          res_val_q <= '0;
        end
      endcase
    end
    if (cmd_i.out_load) begin
      status_o       <= res_st_q;
      result_value_o <= res_val_q;
    end
  end

  assign rsp_valid_o       = out_valid_q;
  assign stat_o.clear_last = (SZW'(clr_q) + SZW'(1)) == size_q;
  assign stat_o.early_done = early_done;
  assign stat_o.hash_done  = hash_done;
  assign stat_o.ev_cont    = (ev == EV_CONT);
  assign stat_o.out_busy   = out_valid_q && !rsp_ready_i;

  `LPHT_ASSERT(a_count_in_size, count_q <= size_q)
  `LPHT_ASSERT(a_read_in_range, cmd_i.rd |-> (SZW'(pos_q) < size_q))
  `LPHT_ASSERT_NEVER(a_out_overwrite, cmd_i.out_load && out_valid_q && !rsp_ready_i)

endmodule
`default_nettype wire

// ===== rtl/core/linear_probe_hash_table.sv =====
// Top level of the linear probing key/value hash table
`default_nettype none
// Open-addressing table of 64-bit keys and values with linear probing and
// tombstones; the home slot is the SplitMix64 mix of the key modulo table_size.
// One request is in work at a time. A request rejected by its checks (null
// value, full table, empty table, unused type) is answered without hashing.
// Otherwise the home slot unit runs six 32x32 multiplies on one shared
// multiplier and then 4-bit remainder steps, and each probe is a registered
// slot read followed by its evaluation. The next request is taken while the
// previous result waits in the output register. After reset and after every
// table_size write the slot states are swept clear, one slot a cycle, during
// which no request is taken.
module linear_probe_hash_table #(
  parameter int SLOTS = lpht_pkg::SLOTS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lpht_req_if.sink    req_i,
  lpht_rsp_if.source  rsp_o,
  lpht_cfg_if.sink    cfg_i
);
  import lpht_pkg::*;

  lpht_cmd_t  cmd;
  lpht_stat_t stat;
  logic       cfg_we;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  lpht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lpht_dp #(.SLOTS(SLOTS)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_size_i     (cfg_i.table_size),
    .req_type_i     (req_i.req_type),
    .key_i          (req_i.key),
    .value_i        (req_i.value),
    .rsp_ready_i    (rsp_o.ready),
    .rsp_valid_o    (rsp_o.valid),
    .status_o       (rsp_o.status),
    .result_value_o (rsp_o.result_value),
    .cmd_i          (cmd),
    .stat_o         (stat)
  );

endmodule
`default_nettype wire
